// File: hdl/etc_pkg.sv
// ============================================================================
// Encoder turn controller package
// Shared widths, codes, state type and unit status type.
// ============================================================================
package etc_pkg;

    localparam int TGT_W      = 26;
    localparam int ANG_W      = 11;
    localparam int PWM_W      = 7;
    localparam int CPD_W      = 16;
    localparam int MODE_W     = 2;
    localparam int PWR_W      = 8;
    localparam int OUT_DATA_W = 24;

    localparam int MUL_A_W    = 26;
    localparam int MUL_B_W    = 11;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
    localparam int DIV_N_W    = 33;
    localparam int DIV_Q_W    = 7;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] CFG_TURN_ANGLE = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CLOCKWISE  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_BASE_PWM   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_PWM    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_CPD        = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_TURN_MODE  = 3'd5;

    localparam logic [MODE_W-1:0] MODE_SPIN      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PIVOT_FWD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PIVOT_BWD = 2'd2;

    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic [ANG_W-1:0] ANGLE_RST     = 11'd90;
    localparam logic             CLOCKWISE_RST = 1'b1;
    localparam logic [PWM_W-1:0] BASE_PWM_RST  = 7'd50;
    localparam logic [PWM_W-1:0] MIN_PWM_RST   = 7'd10;
    localparam logic [CPD_W-1:0] CPD_RST       = 16'd256;
    localparam logic [MODE_W-1:0] MODE_RST     = 2'd0;

    localparam logic [PWR_W-1:0] PWR_ONE       = 8'h01;
    localparam logic [PWR_W-1:0] PWR_MINUS_ONE = 8'hFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TGT_MUL,
        ST_EVAL,
        ST_L_MUL,
        ST_L_DIV,
        ST_R_MUL,
        ST_R_DIV,
        ST_OUT
    } etc_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } etc_sts_t;

endpackage

// File: hdl/etc_mul.sv
// ============================================================================
// Encoder turn controller shift-add multiplier
// Unsigned multiply, one multiplier bit per cycle.
// ============================================================================
module etc_mul
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [etc_pkg::MUL_A_W-1:0]  a,
    input  logic [etc_pkg::MUL_B_W-1:0]  b,
    output logic [etc_pkg::MUL_P_W-1:0]  product,
    output etc_pkg::etc_sts_t            sts
);

    localparam int CNT_W = $clog2(etc_pkg::MUL_B_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(etc_pkg::MUL_B_W - 1);

    logic                         busy_reg;
    logic                         done_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic [etc_pkg::MUL_P_W-1:0]  acc_reg;
    logic [etc_pkg::MUL_P_W-1:0]  acc_next;
    logic [etc_pkg::MUL_P_W-1:0]  a_sh_reg;
    logic [etc_pkg::MUL_B_W-1:0]  b_sh_reg;

    always_comb
    begin
        acc_next = acc_reg;
        if (b_sh_reg[0])
        begin
            acc_next = acc_reg + a_sh_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_LAST;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg  <= '0;
            a_sh_reg <= etc_pkg::MUL_P_W'(a);
            b_sh_reg <= b;
        end
        else if (busy_reg)
        begin
            acc_reg  <= acc_next;
            a_sh_reg <= a_sh_reg << 1;
            b_sh_reg <= b_sh_reg >> 1;
        end
    end

    assign product  = acc_reg;
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

endmodule

// File: hdl/etc_div.sv
// ============================================================================
// Encoder turn controller restoring divider
// Unsigned divide, one quotient bit per cycle, most significant bit first.
// ============================================================================
module etc_div
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [etc_pkg::DIV_N_W-1:0]  dividend,
    input  logic [etc_pkg::TGT_W-1:0]    divisor,
    output logic [etc_pkg::DIV_Q_W-1:0]  quotient,
    output etc_pkg::etc_sts_t            sts
);

    localparam int CNT_W = $clog2(etc_pkg::DIV_Q_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(etc_pkg::DIV_Q_W - 1);

    logic                         busy_reg;
    logic                         done_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic [etc_pkg::DIV_N_W-1:0]  rem_reg;
    logic [etc_pkg::DIV_N_W-1:0]  rem_next;
    logic [etc_pkg::DIV_N_W-1:0]  dsh_reg;
    logic [etc_pkg::DIV_Q_W-1:0]  q_reg;
    logic                         fits;

    always_comb
    begin
        fits     = rem_reg >= dsh_reg;
        rem_next = rem_reg;
        if (fits)
        begin
            rem_next = rem_reg - dsh_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_LAST;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            dsh_reg <= etc_pkg::DIV_N_W'(divisor) << (etc_pkg::DIV_Q_W - 1);
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dsh_reg <= dsh_reg >> 1;
            q_reg   <= {q_reg[etc_pkg::DIV_Q_W-2:0], fits};
        end
    end

    assign quotient = q_reg;
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

endmodule

// File: hdl/encoder_turn_controller_top.sv
// ============================================================================
// Encoder turn controller
// Turns a two-wheel robot from encoder samples in spin or pivot modes.
// ============================================================================
//  Channel  | Signals                           | Transaction
//  ---------+-----------------------------------+------------------------------
//  s_axis   | s_tvalid s_tready s_tdata s_tuser | start or tick with counts
//  m_axis   | m_tvalid m_tready m_tdata         | power commands and flags
//  cfg      | cfg_we cfg_addr cfg_wdata         | register write, no wait
//
//  A spin tick with both wheels running uses a shared 11-step shift-add
//  multiplier and a 7-step restoring divider, run once per wheel. A spin
//  tick with one wheel running runs them once, a start runs the multiplier
//  once for the target, and pivot, finishing and idle ticks use neither.
//  One transaction is in work at a time; the output register lets the next
//  transaction in while a result waits. Reset clears the turn state and loads
//  the register defaults.
// ============================================================================
module encoder_turn_controller_top
#(
    parameter int COUNT_BITS = 24
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // left_count, right_count
    input  logic [((2*COUNT_BITS+7)/8)*8-1:0]      s_tdata,
    // op
    input  logic                                   s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // left_power, right_power, reset_counts, stop_motors, busy_res
    output logic [etc_pkg::OUT_DATA_W-1:0]         m_tdata,
    input  logic                                   cfg_we,
    input  logic [etc_pkg::CFG_ADDR_W-1:0]         cfg_addr,
    input  logic [etc_pkg::CFG_DATA_W-1:0]         cfg_wdata
);

    localparam int SP_W  = (COUNT_BITS + 8 > etc_pkg::TGT_W) ?
                           COUNT_BITS + 8 : etc_pkg::TGT_W;
    localparam int AVE_W = etc_pkg::TGT_W - 8;
    localparam int CMP_W = (COUNT_BITS > AVE_W) ? COUNT_BITS : AVE_W;

    logic [etc_pkg::ANG_W-1:0]   angle_reg;
    logic                        cw_reg;
    logic [etc_pkg::PWM_W-1:0]   base_reg;
    logic [etc_pkg::PWM_W-1:0]   min_reg;
    logic [etc_pkg::CPD_W-1:0]   cpd_reg;
    logic [etc_pkg::MODE_W-1:0]  mode_reg;

    etc_pkg::etc_state_t         state_reg;
    etc_pkg::etc_state_t         state_next;

    logic [etc_pkg::TGT_W-1:0]   tgt_reg;
    logic                        l_run_reg;
    logic                        r_run_reg;
    logic                        active_reg;
    logic [COUNT_BITS-1:0]       lc_reg;
    logic [COUNT_BITS-1:0]       rc_reg;
    logic [etc_pkg::PWR_W-1:0]   res_lp_reg;
    logic [etc_pkg::PWR_W-1:0]   res_rp_reg;
    logic                        res_rst_reg;
    logic                        res_stp_reg;
    logic                        m_valid_reg;
    logic [etc_pkg::OUT_DATA_W-1:0] m_data_reg;

    logic                        accept;
    logic [COUNT_BITS-1:0]       l_raw;
    logic [COUNT_BITS-1:0]       r_raw;
    logic [COUNT_BITS-1:0]       l_abs;
    logic [COUNT_BITS-1:0]       r_abs;
    logic [etc_pkg::ANG_W-1:0]   ang_abs;
    logic [SP_W-1:0]             tgt_ext;
    logic [SP_W-1:0]             l_scaled;
    logic [SP_W-1:0]             r_scaled;
    logic [SP_W-1:0]             l_diff;
    logic [SP_W-1:0]             r_diff;
    logic                        l_run_new;
    logic                        r_run_new;
    logic [COUNT_BITS:0]         cnt_sum;
    logic                        pv_done;
    logic                        is_pivot;
    logic [etc_pkg::PWR_W-1:0]   base_pos;
    logic [etc_pkg::PWR_W-1:0]   base_neg;
    logic [etc_pkg::PWM_W-1:0]   mag;
    logic [etc_pkg::PWR_W-1:0]   mag_pos;
    logic [etc_pkg::PWR_W-1:0]   mag_neg;

    logic                        mul_start;
    logic [etc_pkg::MUL_A_W-1:0] mul_a;
    logic [etc_pkg::MUL_B_W-1:0] mul_b;
    logic [etc_pkg::MUL_P_W-1:0] mul_p;
    etc_pkg::etc_sts_t           mul_sts;
    logic                        div_start;
    logic [etc_pkg::DIV_Q_W-1:0] div_q;
    etc_pkg::etc_sts_t           div_sts;
    logic                        load_out;

    etc_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .product (mul_p),
        .sts     (mul_sts)
    );

    etc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mul_p[etc_pkg::DIV_N_W-1:0]),
        .divisor  (tgt_reg),
        .quotient (div_q),
        .sts      (div_sts)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg <= etc_pkg::ANGLE_RST;
            cw_reg    <= etc_pkg::CLOCKWISE_RST;
            base_reg  <= etc_pkg::BASE_PWM_RST;
            min_reg   <= etc_pkg::MIN_PWM_RST;
            cpd_reg   <= etc_pkg::CPD_RST;
            mode_reg  <= etc_pkg::MODE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                etc_pkg::CFG_TURN_ANGLE: angle_reg <= cfg_wdata[etc_pkg::ANG_W-1:0];
                etc_pkg::CFG_CLOCKWISE:  cw_reg    <= cfg_wdata[0];
                etc_pkg::CFG_BASE_PWM:   base_reg  <= cfg_wdata[etc_pkg::PWM_W-1:0];
                etc_pkg::CFG_MIN_PWM:    min_reg   <= cfg_wdata[etc_pkg::PWM_W-1:0];
                etc_pkg::CFG_CPD:        cpd_reg   <= cfg_wdata[etc_pkg::CPD_W-1:0];
                etc_pkg::CFG_TURN_MODE:  mode_reg  <= cfg_wdata[etc_pkg::MODE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        accept   = s_tvalid && s_tready;
        l_raw    = s_tdata[COUNT_BITS-1:0];
        r_raw    = s_tdata[2*COUNT_BITS-1:COUNT_BITS];
        l_abs    = l_raw[COUNT_BITS-1] ? (~l_raw + COUNT_BITS'(1)) : l_raw;
        r_abs    = r_raw[COUNT_BITS-1] ? (~r_raw + COUNT_BITS'(1)) : r_raw;
        ang_abs  = angle_reg[etc_pkg::ANG_W-1] ?
                   (~angle_reg + etc_pkg::ANG_W'(1)) : angle_reg;

        tgt_ext  = SP_W'(tgt_reg);
        l_scaled = SP_W'({lc_reg, 8'h00});
        r_scaled = SP_W'({rc_reg, 8'h00});
        l_diff   = tgt_ext - l_scaled;
        r_diff   = tgt_ext - r_scaled;
        l_run_new = l_run_reg && (l_scaled < tgt_ext);
        r_run_new = r_run_reg && (r_scaled < tgt_ext);

        cnt_sum  = (COUNT_BITS+1)'(lc_reg) + (COUNT_BITS+1)'(rc_reg);
        pv_done  = CMP_W'(cnt_sum[COUNT_BITS:1]) >=
                   CMP_W'(tgt_reg[etc_pkg::TGT_W-1:8]);
        is_pivot = (mode_reg == etc_pkg::MODE_PIVOT_FWD) ||
                   (mode_reg == etc_pkg::MODE_PIVOT_BWD);

        base_pos = {1'b0, base_reg};
        base_neg = ~base_pos + etc_pkg::PWR_ONE;
        mag      = (div_q >= min_reg) ? div_q : min_reg;
        mag_pos  = {1'b0, mag};
        mag_neg  = ~mag_pos + etc_pkg::PWR_ONE;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            etc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == etc_pkg::OP_START)
                    begin
                        state_next = etc_pkg::ST_TGT_MUL;
                    end
                    else if (!active_reg)
                    begin
                        state_next = etc_pkg::ST_OUT;
                    end
                    else
                    begin
                        state_next = etc_pkg::ST_EVAL;
                    end
                end
            end
            etc_pkg::ST_TGT_MUL:
            begin
                if (mul_sts.done)
                begin
                    state_next = etc_pkg::ST_OUT;
                end
            end
            etc_pkg::ST_EVAL:
            begin
                if (is_pivot)
                begin
                    state_next = etc_pkg::ST_OUT;
                end
                else if (l_run_new)
                begin
                    state_next = etc_pkg::ST_L_MUL;
                end
                else if (r_run_new)
                begin
                    state_next = etc_pkg::ST_R_MUL;
                end
                else
                begin
                    state_next = etc_pkg::ST_OUT;
                end
            end
            etc_pkg::ST_L_MUL:
            begin
                if (mul_sts.done)
                begin
                    state_next = etc_pkg::ST_L_DIV;
                end
            end
            etc_pkg::ST_L_DIV:
            begin
                if (div_sts.done)
                begin
                    state_next = r_run_reg ? etc_pkg::ST_R_MUL : etc_pkg::ST_OUT;
                end
            end
            etc_pkg::ST_R_MUL:
            begin
                if (mul_sts.done)
                begin
                    state_next = etc_pkg::ST_R_DIV;
                end
            end
            etc_pkg::ST_R_DIV:
            begin
                if (div_sts.done)
                begin
                    state_next = etc_pkg::ST_OUT;
                end
            end
            etc_pkg::ST_OUT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    state_next = etc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = etc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready  = 1'b0;
        mul_start = 1'b0;
        mul_a     = l_diff[etc_pkg::MUL_A_W-1:0];
        mul_b     = etc_pkg::MUL_B_W'(base_reg);
        div_start = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            etc_pkg::ST_IDLE:
            begin
                s_tready  = 1'b1;
                mul_start = accept && (s_tuser == etc_pkg::OP_START);
                mul_a     = etc_pkg::MUL_A_W'(cpd_reg);
                mul_b     = ang_abs;
            end
            etc_pkg::ST_EVAL:
            begin
                mul_start = !is_pivot && (l_run_new || r_run_new);
                mul_a     = l_run_new ? l_diff[etc_pkg::MUL_A_W-1:0] :
                                        r_diff[etc_pkg::MUL_A_W-1:0];
            end
            etc_pkg::ST_L_MUL, etc_pkg::ST_R_MUL:
            begin
                div_start = mul_sts.done;
            end
            etc_pkg::ST_L_DIV:
            begin
                mul_start = div_sts.done && r_run_reg;
                mul_a     = r_diff[etc_pkg::MUL_A_W-1:0];
            end
            etc_pkg::ST_OUT:
            begin
                load_out = !m_valid_reg || m_tready;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= etc_pkg::ST_IDLE;
            tgt_reg     <= '0;
            l_run_reg   <= 1'b0;
            r_run_reg   <= 1'b0;
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == etc_pkg::ST_TGT_MUL && mul_sts.done)
            begin
                tgt_reg    <= mul_p[etc_pkg::TGT_W-1:0];
                l_run_reg  <= 1'b1;
                r_run_reg  <= 1'b1;
                active_reg <= 1'b1;
            end
            if (state_reg == etc_pkg::ST_EVAL)
            begin
                if (is_pivot)
                begin
                    if (pv_done)
                    begin
                        active_reg <= 1'b0;
                    end
                end
                else
                begin
                    l_run_reg <= l_run_new;
                    r_run_reg <= r_run_new;
                    if (!l_run_new && !r_run_new)
                    begin
                        active_reg <= 1'b0;
                    end
                end
            end
            if (load_out)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lc_reg      <= l_abs;
            rc_reg      <= r_abs;
            res_lp_reg  <= '0;
            res_rp_reg  <= '0;
            res_rst_reg <= (s_tuser == etc_pkg::OP_START);
            res_stp_reg <= 1'b0;
        end
        if (state_reg == etc_pkg::ST_EVAL)
        begin
            if (is_pivot)
            begin
                if (pv_done)
                begin
                    res_stp_reg <= 1'b1;
                end
                else if (mode_reg == etc_pkg::MODE_PIVOT_FWD)
                begin
                    res_lp_reg <= cw_reg ? base_pos : etc_pkg::PWR_MINUS_ONE;
                    res_rp_reg <= cw_reg ? etc_pkg::PWR_MINUS_ONE : base_pos;
                end
                else
                begin
                    res_lp_reg <= cw_reg ? etc_pkg::PWR_ONE : base_neg;
                    res_rp_reg <= cw_reg ? base_neg : etc_pkg::PWR_ONE;
                end
            end
            else if (!l_run_new && !r_run_new)
            begin
                res_stp_reg <= 1'b1;
            end
        end
        if (state_reg == etc_pkg::ST_L_DIV && div_sts.done)
        begin
            res_lp_reg <= cw_reg ? mag_pos : mag_neg;
        end
        if (state_reg == etc_pkg::ST_R_DIV && div_sts.done)
        begin
            res_rp_reg <= cw_reg ? mag_neg : mag_pos;
        end
        if (load_out)
        begin
            m_data_reg <= {5'b00000, active_reg, res_stp_reg, res_rst_reg,
                           res_rp_reg, res_lp_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_sts.busy && div_sts.busy))
        else $error("multiplier and divider busy together");

    a_left_div_running: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == etc_pkg::ST_L_DIV) |-> l_run_reg)
        else $error("left wheel divided while stopped");

    a_stop_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_data_reg[17]) |-> !m_data_reg[18])
        else $error("stop reported while turn still busy");

    a_start_zero_power: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_data_reg[16]) |-> (m_data_reg[15:0] == 16'h0000))
        else $error("start result carries motor power");
`endif

endmodule
